// ===== rtl/nsed_pkg.sv =====
// Shared types and constants for the nearest-string edit distance block.
package nsed_pkg;

	localparam int MAX_LEN_DEF  = 32;
	localparam int MAX_CAND_DEF = 256;

	localparam logic [1:0] OP_SRC  = 2'd0;
	localparam logic [1:0] OP_CAND = 2'd1;
	localparam logic [1:0] OP_NEW  = 2'd2;

	// One candidate byte travelling down the row of cells.
	typedef struct packed {
		logic       valid;
		logic [7:0] ch;
		logic       last;
		logic       upd;
		logic       trunc;
	} nsed_tok_t;

	// Broadcast from the input stage to every cell.
	typedef struct packed {
		logic       adv;
		logic       init;
		logic       wr;
		logic [7:0] ch;
	} nsed_ctl_t;

endpackage

// ===== rtl/nsed_cell.sv =====
// One cell of the edit distance row: a source byte and one column of the table.
module nsed_cell #(
	parameter int IDX = 1,
	parameter int LW  = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nsed_pkg::nsed_ctl_t ctl,
	input  logic [LW-1:0]     src_len,
	input  nsed_pkg::nsed_tok_t tok_in,
	input  logic [LW-1:0]     left_in,
	input  logic [LW-1:0]     diag_in,
	output nsed_pkg::nsed_tok_t tok_s1,
	output logic [LW-1:0]     left_s1,
	output logic [LW-1:0]     diag_s1
);
	import nsed_pkg::*;

	logic [7:0]    char_q;
	logic [LW-1:0] val_q;
	logic          active;
	logic [LW-1:0] mn;
	logic [LW-1:0] nxt;

	assign active = (LW'(IDX) <= src_len);

	always_comb begin
		mn = (left_in < val_q) ? left_in : val_q;
		if (diag_in < mn) begin
			mn = diag_in;
		end
		nxt = (char_q == tok_in.ch) ? diag_in : LW'(mn + 1'b1);
	end

	always_ff @(posedge clk) begin
		if (ctl.wr && (src_len == LW'(IDX - 1))) begin
			char_q <= ctl.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q  <= LW'(IDX);
			tok_s1 <= '0;
		end else begin
			if (ctl.init) begin
				val_q <= LW'(IDX);
			end else if (ctl.adv && tok_in.valid && active) begin
				if (tok_in.last) begin
					val_q <= LW'(IDX);
				end else if (tok_in.upd) begin
					val_q <= nxt;
				end
			end
			if (ctl.adv) begin
				tok_s1 <= tok_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			if (!active) begin
				left_s1 <= left_in;
			end else if (tok_in.upd) begin
				left_s1 <= nxt;
			end else begin
				left_s1 <= val_q;
			end
			diag_s1 <= val_q;
		end
	end

endmodule

// ===== rtl/nsed_collect.sv =====
// Result stage: best-candidate tracking, candidate count and the output register.
module nsed_collect #(
	parameter int LW             = 6,
	parameter int MAX_CANDIDATES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  nsed_pkg::nsed_tok_t tok,
	input  logic [LW-1:0]     row_dist,
	input  logic              out_ready,
	output logic              hold,
	output logic              out_valid,
	output logic [5:0]        distance,
	output logic [7:0]        cand_index,
	output logic [5:0]        best_distance,
	output logic [7:0]        best_index,
	output logic              truncated
);
	import nsed_pkg::*;

	localparam int CW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

	logic [CW-1:0] cnt_q;
	logic [LW-1:0] best_d_q;
	logic [CW-1:0] best_i_q;
	logic          best_v_q;
	logic          take;
	logic          better;
	logic [LW-1:0] nbd;
	logic [CW-1:0] nbi;

	logic [LW+5:0] dist_x;
	logic [LW+5:0] bd_x;
	logic [CW+7:0] idx_x;
	logic [CW+7:0] bi_x;

	assign hold   = tok.valid && tok.last && out_valid && !out_ready;
	assign take   = tok.valid && tok.last && !hold;
	assign better = !best_v_q || (row_dist < best_d_q);
	assign nbd    = better ? row_dist : best_d_q;
	assign nbi    = better ? cnt_q : best_i_q;

	assign dist_x = {6'd0, row_dist};
	assign bd_x   = {6'd0, nbd};
	assign idx_x  = {8'd0, cnt_q};
	assign bi_x   = {8'd0, nbi};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			best_d_q  <= '0;
			best_i_q  <= '0;
			best_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (clr) begin
				cnt_q    <= '0;
				best_d_q <= '0;
				best_i_q <= '0;
				best_v_q <= 1'b0;
			end else if (take) begin
				best_d_q <= nbd;
				best_i_q <= nbi;
				best_v_q <= 1'b1;
				cnt_q    <= (cnt_q == CW'(MAX_CANDIDATES - 1)) ? '0 : CW'(cnt_q + 1'b1);
			end
			if (take) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			distance      <= (dist_x > (LW + 6)'(63)) ? 6'd63 : dist_x[5:0];
			best_distance <= (bd_x > (LW + 6)'(63)) ? 6'd63 : bd_x[5:0];
			cand_index    <= idx_x[7:0];
			best_index    <= bi_x[7:0];
			truncated     <= tok.trunc;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> !take)
		else $error("result taken while output register is blocked");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && !clr) |=> best_v_q)
		else $error("best candidate not marked valid after a result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && !clr && best_v_q) |=> (best_d_q <= $past(best_d_q)))
		else $error("best distance grew within a search");

endmodule

// ===== rtl/nearest_string_edit_distance.sv =====
// Top level of the nearest-string edit distance search: input stage, cell row and result stage.
//
//   channel  | signals                                              | dir
//   ---------+------------------------------------------------------+-----
//   input    | in_valid, in_ready, op, ch, last                     | in
//   result   | out_valid, out_ready, distance, cand_index,          | out
//            | best_distance, best_index, truncated                 |
//
// Candidate bytes enter one per cycle while the row is not frozen and ripple down a row of
// MAX_LEN cells, one cell per source byte; a candidate's result is taken from the last cell into the output register.
// Source bytes, new-search items and unused codes wait until the row holds no byte.
// After reset the block is empty and accepts items at once; no clearing pass is needed.
// A result that cannot leave because the output register is still full freezes the row.
module nearest_string_edit_distance #(
	parameter int MAX_LEN        = nsed_pkg::MAX_LEN_DEF,
	parameter int MAX_CANDIDATES = nsed_pkg::MAX_CAND_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] distance,
	output logic [7:0] cand_index,
	output logic [5:0] best_distance,
	output logic [7:0] best_index,
	output logic       truncated
);
	import nsed_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);

	nsed_tok_t     tok_w  [0:MAX_LEN];
	logic [LW-1:0] left_w [0:MAX_LEN];
	logic [LW-1:0] diag_w [0:MAX_LEN];
	logic [MAX_LEN:0] vld;

	nsed_tok_t     inj_tok_s1;
	logic [LW-1:0] inj_left_s1;
	logic [LW-1:0] inj_diag_s1;

	logic [LW-1:0] src_len_q;
	logic [LW-1:0] cand_len_q;
	logic          overflow_q;

	nsed_ctl_t ctl;
	logic      hold;
	logic      busy;
	logic      acc;
	logic      is_src;
	logic      is_cand;
	logic      is_new;
	logic      upd;
	logic      src_room;

	assign busy     = |vld;
	assign in_ready = !hold && ((op == OP_CAND) || !busy);
	assign acc      = in_valid && in_ready;
	assign upd      = cand_len_q < LW'(MAX_LEN);
	assign src_room = src_len_q < LW'(MAX_LEN);

	always_comb begin
		is_src  = 1'b0;
		is_cand = 1'b0;
		is_new  = 1'b0;
		unique case (op)
			OP_SRC:  is_src  = acc;
			OP_CAND: is_cand = acc;
			OP_NEW:  is_new  = acc;
			default: ;
		endcase
	end

	assign ctl.adv  = !hold;
	assign ctl.init = is_src || is_new;
	assign ctl.wr   = is_src && src_room;
	assign ctl.ch   = ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_len_q  <= '0;
			cand_len_q <= '0;
			overflow_q <= 1'b0;
			inj_tok_s1 <= '0;
		end else begin
			if (is_new) begin
				src_len_q  <= '0;
				cand_len_q <= '0;
				overflow_q <= 1'b0;
			end else if (is_src) begin
				cand_len_q <= '0;
				if (src_room) begin
					src_len_q <= LW'(src_len_q + 1'b1);
				end else begin
					overflow_q <= 1'b1;
				end
			end else if (is_cand) begin
				if (!upd) begin
					overflow_q <= 1'b1;
				end
				if (last) begin
					cand_len_q <= '0;
				end else if (upd) begin
					cand_len_q <= LW'(cand_len_q + 1'b1);
				end
			end
			if (!hold) begin
				inj_tok_s1.valid <= is_cand;
				inj_tok_s1.ch    <= ch;
				inj_tok_s1.last  <= last;
				inj_tok_s1.upd   <= upd;
				inj_tok_s1.trunc <= overflow_q || !upd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			inj_left_s1 <= upd ? LW'(cand_len_q + 1'b1) : cand_len_q;
			inj_diag_s1 <= cand_len_q;
		end
	end

	assign tok_w[0]  = inj_tok_s1;
	assign left_w[0] = inj_left_s1;
	assign diag_w[0] = inj_diag_s1;

	for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
		nsed_cell #(
			.IDX (k),
			.LW  (LW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.src_len (src_len_q),
			.tok_in  (tok_w[k-1]),
			.left_in (left_w[k-1]),
			.diag_in (diag_w[k-1]),
			.tok_s1  (tok_w[k]),
			.left_s1 (left_w[k]),
			.diag_s1 (diag_w[k])
		);
	end

	for (genvar k = 0; k <= MAX_LEN; k++) begin : g_vld
		assign vld[k] = tok_w[k].valid;
	end

	nsed_collect #(
		.LW             (LW),
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_collect (
		.clk           (clk),
		.arst_n        (arst_n),
		.clr           (is_new),
		.tok           (tok_w[MAX_LEN]),
		.row_dist      (left_w[MAX_LEN]),
		.out_ready     (out_ready),
		.hold          (hold),
		.out_valid     (out_valid),
		.distance      (distance),
		.cand_index    (cand_index),
		.best_distance (best_distance),
		.best_index    (best_index),
		.truncated     (truncated)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (op != OP_CAND)) |-> !busy)
		else $error("source or new-search item taken while the row holds a byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		(src_len_q <= LW'(MAX_LEN)) && (cand_len_q <= LW'(MAX_LEN)))
		else $error("string length beyond the row");
	assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> $stable(tok_w[MAX_LEN]))
		else $error("row moved while a result was blocked");
	assert property (@(posedge clk) disable iff (!arst_n)
		is_new |=> (src_len_q == '0) && (cand_len_q == '0) && !overflow_q)
		else $error("new search did not clear the input stage");

endmodule
